/* rtl/core/cpa_pkg.sv */
// Shared types, codes and constants of the contiguous page allocator.
package cpa_pkg;

    localparam int NUM_PAGES_DEFAULT = 16384;
    localparam int MAX_RUN_DEFAULT   = 256;

    localparam int PAGE_W     = 14;
    localparam int END_W      = 15;
    localparam int COUNT_W    = 9;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;
    localparam int RUN_CMP_W  = 13;
    localparam int POS_MIN_W  = 17;

    localparam logic [PAGE_W-1:0] START_RESET = 14'd1024;
    localparam logic [END_W-1:0]  END_RESET   = 15'd16384;

    typedef enum logic [0:0] {
        KIND_ALLOC = 1'b0,
        KIND_FREE  = 1'b1
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NO_RUN   = 2'd1,
        STATUS_BAD_FREE = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REGION_START = 1'b0,
        REG_REGION_END   = 1'b1
    } reg_idx_t;

    typedef struct packed {
        kind_t               kind;
        logic [PAGE_W-1:0]   page_index;
        logic [COUNT_W-1:0]  count;
    } item_t;

    typedef struct packed {
        status_t             status;
        logic [PAGE_W-1:0]   first_page;
    } result_t;

endpackage

/* rtl/core/cpa_if.sv */
// Channel interfaces: request, response and configuration write.
interface cpa_req_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [cpa_pkg::PAGE_W-1:0]    page_index;
    logic [cpa_pkg::COUNT_W-1:0]   count;

    modport source (output valid, kind, page_index, count, input ready);
    modport sink   (input valid, kind, page_index, count, output ready);
endinterface

interface cpa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [cpa_pkg::STATUS_W-1:0]  status;
    logic [cpa_pkg::PAGE_W-1:0]    first_page;

    modport source (output valid, status, first_page, input ready);
    modport sink   (input valid, status, first_page, output ready);
endinterface

interface cpa_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [cpa_pkg::CFG_IDX_W-1:0]  index;
    logic [cpa_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/contiguous_page_allocator.sv */
// Top level of the next-fit contiguous page allocator.
//
// Channels: req (sink) carries one request beat: kind (allocate or free),
// page_index (first page to free, ignored on allocate) and count (run
// length). rsp (source) returns exactly one beat per request: status and
// first_page. cfg (sink) writes region_start (index 0) or region_end
// (index 1); it is always ready and must only be used while idle.
//
// Sequencing: one request at a time. A request occupies the page scan
// sequencer, which reads page marks one at a time through the single read
// port of the mark memory. A free checks each page of its run, then clears
// them; an allocate probes each window page by page, steps or wraps the
// window, then marks the run, and at worst scans the whole region.
// Reset: every page mark is cleared by a pass over all pages, one
// page a cycle; req stays not ready during the pass, cfg is taken as ever.
// The next-fit pointer and region registers return to their reset values.
// Stall: the result sits in an output register; while rsp is stalled the
// next request is still taken and processed, then holds until the register
// frees.
module contiguous_page_allocator #(
    parameter int NUM_PAGES = cpa_pkg::NUM_PAGES_DEFAULT,
    parameter int MAX_RUN   = cpa_pkg::MAX_RUN_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    cpa_req_if.sink   req,
    cpa_rsp_if.source rsp,
    cpa_cfg_if.sink   cfg
);

    localparam int AW = $clog2(NUM_PAGES);

    logic [cpa_pkg::PAGE_W-1:0] region_start_reg;
    logic [cpa_pkg::END_W-1:0]  region_end_reg;
    logic                       out_valid_reg;
    cpa_pkg::result_t           out_reg;

    cpa_pkg::item_t   item;
    cpa_pkg::result_t res;
    logic             res_valid;
    logic             res_ready;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic             mem_wdata;
    logic [AW-1:0]    mem_raddr;
    logic             mem_rdata;

    // Configuration: always ready, write on each beat.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_start_reg <= cpa_pkg::START_RESET;
            region_end_reg   <= cpa_pkg::END_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                cpa_pkg::REG_REGION_START:
                begin
                    region_start_reg <= cfg.data[cpa_pkg::PAGE_W-1:0];
                end
                cpa_pkg::REG_REGION_END:
                begin
                    region_end_reg <= cfg.data[cpa_pkg::END_W-1:0];
                end
                default:
                begin
                    region_end_reg <= region_end_reg;
                end
            endcase
        end
    end

    // Pack the request beat.
    always_comb
    begin
        item.kind       = cpa_pkg::kind_t'(req.kind);
        item.page_index = req.page_index;
        item.count      = req.count;
    end

    cpa_seq #(
        .NUM_PAGES (NUM_PAGES),
        .MAX_RUN   (MAX_RUN)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (req.valid),
        .in_ready     (req.ready),
        .item         (item),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .region_start (region_start_reg),
        .region_end   (region_end_reg),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata)
    );

    cpa_page_mem #(
        .DEPTH (NUM_PAGES)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Output register: load when empty or being drained this cycle.
    assign res_ready = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_reg.status;
    assign rsp.first_page = out_reg.first_page;

endmodule

/* rtl/core/cpa_page_mem.sv */
// Single-bit page mark memory, one write and one registered read port.
module cpa_page_mem #(
    parameter int DEPTH = cpa_pkg::NUM_PAGES_DEFAULT
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic                     wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic                     rdata
);

    logic mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/cpa_seq.sv */
// Sequencer: clearing pass, next-fit window scan, marking and freeing.
module cpa_seq #(
    parameter int NUM_PAGES = cpa_pkg::NUM_PAGES_DEFAULT,
    parameter int MAX_RUN   = cpa_pkg::MAX_RUN_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  cpa_pkg::item_t               item,
    output logic                         res_valid,
    input  logic                         res_ready,
    output cpa_pkg::result_t             res,
    input  logic [cpa_pkg::PAGE_W-1:0]   region_start,
    input  logic [cpa_pkg::END_W-1:0]    region_end,
    output logic                         mem_we,
    output logic [$clog2(NUM_PAGES)-1:0] mem_waddr,
    output logic                         mem_wdata,
    output logic [$clog2(NUM_PAGES)-1:0] mem_raddr,
    input  logic                         mem_rdata
);

    localparam int AW = $clog2(NUM_PAGES);
    localparam int PW = (AW + 1 > cpa_pkg::POS_MIN_W) ? AW + 1 : cpa_pkg::POS_MIN_W;
    localparam logic [PW-1:0] LAST_PAGE = PW'(NUM_PAGES - 1);
    localparam logic [PW-1:0] PAGES     = PW'(NUM_PAGES);

    typedef enum logic [11:0] {
        S_CLEAR  = 12'b0000_0000_0001,
        S_IDLE   = 12'b0000_0000_0010,
        S_ASTART = 12'b0000_0000_0100,
        S_WIN    = 12'b0000_0000_1000,
        S_ARD    = 12'b0000_0001_0000,
        S_ACHK   = 12'b0000_0010_0000,
        S_MARK   = 12'b0000_0100_0000,
        S_FSTART = 12'b0000_1000_0000,
        S_FRD    = 12'b0001_0000_0000,
        S_FCHK   = 12'b0010_0000_0000,
        S_FCLR   = 12'b0100_0000_0000,
        S_RESP   = 12'b1000_0000_0000
    } state_t;

    state_t                      state_reg, state_next;
    cpa_pkg::item_t              item_reg, item_next;
    cpa_pkg::result_t            res_reg, res_next;
    logic [PW-1:0]               win_reg, win_next;
    logic [PW-1:0]               addr_reg, addr_next;
    logic [PW-1:0]               scanned_reg, scanned_next;
    logic [PW-1:0]               total_reg, total_next;
    logic [PW-1:0]               next_search_reg, next_search_next;
    logic [cpa_pkg::COUNT_W-1:0] k_reg, k_next;

    logic [PW-1:0] start_w, end_w, n_w, first_w;
    logic [PW-1:0] win_plus_n, first_plus_n;
    logic          run_bad, k_last, ptr_in;

    // Effective end is the smaller of the register and the store size.
    always_comb
    begin
        start_w = PW'(region_start);
        end_w   = (PW'(region_end) < PAGES) ? PW'(region_end) : PAGES;
        n_w     = PW'(item_reg.count);
        first_w = PW'(item_reg.page_index);
    end

    assign win_plus_n   = win_reg + n_w;
    assign first_plus_n = first_w + n_w;
    assign run_bad      = (item_reg.count == '0) ||
                          (cpa_pkg::RUN_CMP_W'(item_reg.count) >
                           cpa_pkg::RUN_CMP_W'(MAX_RUN));
    assign k_last       = (k_reg == item_reg.count - cpa_pkg::COUNT_W'(1));
    assign ptr_in       = (next_search_reg >= start_w) && (next_search_reg < end_w);

    assign mem_waddr = addr_reg[AW-1:0];
    assign mem_raddr = addr_reg[AW-1:0];
    assign res       = res_reg;

    always_comb
    begin
        state_next       = state_reg;
        item_next        = item_reg;
        res_next         = res_reg;
        win_next         = win_reg;
        addr_next        = addr_reg;
        scanned_next     = scanned_reg;
        total_next       = total_reg;
        next_search_next = next_search_reg;
        k_next           = k_reg;
        in_ready         = 1'b0;
        res_valid        = 1'b0;
        mem_we           = 1'b0;
        mem_wdata        = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                addr_next = addr_reg + PW'(1);
                if (addr_reg == LAST_PAGE)
                begin
                    addr_next  = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    item_next  = item;
                    state_next = (item.kind == cpa_pkg::KIND_FREE) ? S_FSTART : S_ASTART;
                end
            end
            S_ASTART:
            begin
                if (run_bad || (start_w >= end_w))
                begin
                    res_next   = '{cpa_pkg::STATUS_NO_RUN, '0};
                    state_next = S_RESP;
                end
                else
                begin
                    total_next   = end_w - start_w;
                    win_next     = ptr_in ? next_search_reg : start_w;
                    scanned_next = '0;
                    state_next   = S_WIN;
                end
            end
            S_WIN:
            begin
                if (scanned_reg >= total_reg)
                begin
                    res_next   = '{cpa_pkg::STATUS_NO_RUN, '0};
                    state_next = S_RESP;
                end
                else if (win_plus_n <= end_w)
                begin
                    addr_next  = win_reg;
                    k_next     = '0;
                    state_next = S_ARD;
                end
                else
                begin
                    // Wrap: count the tail up to the end as scanned.
                    scanned_next = scanned_reg + ((win_reg < end_w) ? end_w - win_reg : '0);
                    win_next     = start_w;
                end
            end
            S_ARD:
            begin
                state_next = S_ACHK;
            end
            S_ACHK:
            begin
                if (mem_rdata)
                begin
                    scanned_next = scanned_reg + n_w;
                    win_next     = win_plus_n;
                    state_next   = S_WIN;
                end
                else if (k_last)
                begin
                    addr_next  = win_reg;
                    k_next     = '0;
                    state_next = S_MARK;
                end
                else
                begin
                    k_next     = k_reg + cpa_pkg::COUNT_W'(1);
                    addr_next  = addr_reg + PW'(1);
                    state_next = S_ARD;
                end
            end
            S_MARK:
            begin
                mem_we    = 1'b1;
                mem_wdata = 1'b1;
                if (k_last)
                begin
                    next_search_next = (win_plus_n >= end_w) ? start_w : win_plus_n;
                    res_next   = '{cpa_pkg::STATUS_OK, win_reg[cpa_pkg::PAGE_W-1:0]};
                    state_next = S_RESP;
                end
                else
                begin
                    k_next    = k_reg + cpa_pkg::COUNT_W'(1);
                    addr_next = addr_reg + PW'(1);
                end
            end
            S_FSTART:
            begin
                if (run_bad || (first_plus_n > end_w))
                begin
                    res_next   = '{cpa_pkg::STATUS_BAD_FREE, '0};
                    state_next = S_RESP;
                end
                else
                begin
                    addr_next  = first_w;
                    k_next     = '0;
                    state_next = S_FRD;
                end
            end
            S_FRD:
            begin
                state_next = S_FCHK;
            end
            S_FCHK:
            begin
                if (!mem_rdata)
                begin
                    res_next   = '{cpa_pkg::STATUS_BAD_FREE, '0};
                    state_next = S_RESP;
                end
                else if (k_last)
                begin
                    addr_next  = first_w;
                    k_next     = '0;
                    state_next = S_FCLR;
                end
                else
                begin
                    k_next     = k_reg + cpa_pkg::COUNT_W'(1);
                    addr_next  = addr_reg + PW'(1);
                    state_next = S_FRD;
                end
            end
            S_FCLR:
            begin
                mem_we = 1'b1;
                if (k_last)
                begin
                    res_next   = '{cpa_pkg::STATUS_OK, '0};
                    state_next = S_RESP;
                end
                else
                begin
                    k_next    = k_reg + cpa_pkg::COUNT_W'(1);
                    addr_next = addr_reg + PW'(1);
                end
            end
            S_RESP:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            addr_reg        <= '0;
            next_search_reg <= PW'(cpa_pkg::START_RESET);
        end
        else
        begin
            state_reg       <= state_next;
            addr_reg        <= addr_next;
            next_search_reg <= next_search_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        res_reg     <= res_next;
        win_reg     <= win_next;
        scanned_reg <= scanned_next;
        total_reg   <= total_next;
        k_reg       <= k_next;
    end

endmodule

/* rtl/core/cpa_checker.sv */
// Port-level checker for the allocator, bound to the top level.
module cpa_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [cpa_pkg::STATUS_W-1:0] rsp_status,
    input logic [cpa_pkg::PAGE_W-1:0]   rsp_first_page
);

    // Hold the result beat while the receiver stalls.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=>
            (rsp_valid && $stable(rsp_status) && $stable(rsp_first_page)))
        else $error("result beat changed while stalled");

    // One request at a time: drop ready after an accepted beat.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken while another is in flight");

    // Only defined status codes leave the block.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_status == cpa_pkg::STATUS_OK ||
                       rsp_status == cpa_pkg::STATUS_NO_RUN ||
                       rsp_status == cpa_pkg::STATUS_BAD_FREE))
        else $error("undefined status code");

    // Failed requests carry no page.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_status != cpa_pkg::STATUS_OK) |-> (rsp_first_page == '0))
        else $error("failed request returned a page");

endmodule

bind contiguous_page_allocator cpa_checker u_cpa_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.status),
    .rsp_first_page (rsp.first_page)
);

/* dv/tb_contiguous_page_allocator.sv */
// Self-checking testbench for the next-fit contiguous page allocator.
`timescale 1ns / 100ps

module tb_contiguous_page_allocator;
    import cpa_pkg::*;

    localparam int NUM_PAGES   = NUM_PAGES_DEFAULT;
    localparam int MAX_RUN     = MAX_RUN_DEFAULT;
    localparam int CYCLE_LIMIT = 40000000;
    localparam int NUM_PHASES  = 8;
    localparam int PHASE_ITEMS = 244;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        int first;
        int len;
    } run_t;

    logic clk = 1'b0;
    logic rst_n;

    cpa_req_if req_ch ();
    cpa_rsp_if rsp_ch ();
    cpa_cfg_if cfg_ch ();

    contiguous_page_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always #1 clk = ~clk;

    // Shadow of the allocator: page marks, next-fit pointer and region registers.
    bit                page_busy [NUM_PAGES];
    logic [PAGE_W-1:0] next_fit   = START_RESET;
    logic [PAGE_W-1:0] region_lo  = START_RESET;
    logic [END_W-1:0]  region_hi  = END_RESET;

    // Runs that the shadow has handed out and nobody has freed yet; frees are drawn from here.
    run_t    held_runs [$];
    item_t   requests_pending [$];
    result_t outcomes_due [$];

    int  items_issued  = 0;
    int  taken_count   = 0;
    int  results_seen  = 0;
    int  cfg_beats     = 0;
    int  faults        = 0;
    int  cycle_count   = 0;
    int  send_gap_pct  = 11;
    int  recv_gap_pct  = 67;
    bit  req_took      = 1'b0;

    task automatic note_fault(string msg);
        faults++;
        if (faults <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    // Work out the answer to one request and advance the shadow state the way the block must.
    function automatic result_t allocator_outcome(item_t rq);
        result_t verdict;
        int      n;
        int      lo;
        int      stop_pg;
        int      total;
        int      scanned;
        int      at;
        int      last;
        int      k;
        bit      clear;
        verdict.status     = STATUS_OK;
        verdict.first_page = '0;
        n       = rq.count;
        lo      = region_lo;
        // clamp the end to the size of the mark store
        stop_pg = (region_hi < NUM_PAGES) ? int'(region_hi) : NUM_PAGES;
        if (rq.kind == KIND_ALLOC)
        begin
            verdict.status = STATUS_NO_RUN;
            if (n == 0 || n > MAX_RUN || lo >= stop_pg)
                return verdict;
            total   = stop_pg - lo;
            scanned = 0;
            // a pointer left outside the region restarts the scan at the region start
            at = (next_fit >= lo && next_fit < stop_pg) ? int'(next_fit) : lo;
            while (scanned < total)
            begin
                if (at + n <= stop_pg)
                begin
                    clear = 1'b1;
                    for (k = 0; k < n; k++)
                        if (page_busy[at + k])
                            clear = 1'b0;
                    if (clear)
                    begin
                        for (k = 0; k < n; k++)
                            page_busy[at + k] = 1'b1;
                        next_fit = (at + n >= stop_pg) ? lo[PAGE_W-1:0] : PAGE_W'(at + n);
                        held_runs.push_back('{at, n});
                        verdict.status     = STATUS_OK;
                        verdict.first_page = at[PAGE_W-1:0];
                        return verdict;
                    end
                    scanned += n;
                    at      += n;
                end
                else
                begin
                    // a wrap books the tail of the region as scanned
                    scanned += (at < stop_pg) ? stop_pg - at : 0;
                    at = lo;
                end
            end
            return verdict;
        end
        // free: bounded by the end only, never by the start
        last = int'(rq.page_index) + n;
        if (n == 0 || n > MAX_RUN || last > stop_pg)
        begin
            verdict.status = STATUS_BAD_FREE;
            return verdict;
        end
        for (k = rq.page_index; k < last; k++)
            if (!page_busy[k])
            begin
                verdict.status = STATUS_BAD_FREE;
                return verdict;
            end
        for (k = rq.page_index; k < last; k++)
            page_busy[k] = 1'b0;
        return verdict;
    endfunction

    // Driver: present the next pending request on the falling edge, hold it until its beat.
    always @(negedge clk)
    begin : drive
        item_t nxt;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (!req_ch.valid || req_took)
            begin
                if (requests_pending.size() != 0 && $urandom_range(0, 99) >= send_gap_pct)
                begin
                    nxt = requests_pending.pop_front();
                    req_ch.valid      <= 1'b1;
                    req_ch.kind       <= nxt.kind;
                    req_ch.page_index <= nxt.page_index;
                    req_ch.count      <= nxt.count;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_gap_pct);
        end
    end

    // Monitor: on each rising edge check a response beat, then take in request and config beats.
    always @(posedge clk)
    begin : watch
        item_t   seen;
        result_t want;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                results_seen++;
                if (outcomes_due.size() == 0)
                begin
                    note_fault($sformatf("response %0d with nothing outstanding: status %0d page %0d",
                        results_seen, rsp_ch.status, rsp_ch.first_page));
                end
                else
                begin
                    want = outcomes_due.pop_front();
                    if (rsp_ch.status !== want.status || rsp_ch.first_page !== want.first_page)
                        note_fault($sformatf(
                            "response %0d: status exp %0d got %0d, first_page exp %0d got %0d",
                            results_seen, want.status, rsp_ch.status,
                            want.first_page, rsp_ch.first_page));
                end
            end
            req_took = req_ch.valid && req_ch.ready;
            if (req_took)
            begin
                seen.kind       = kind_t'(req_ch.kind);
                seen.page_index = req_ch.page_index;
                seen.count      = req_ch.count;
                outcomes_due.push_back(allocator_outcome(seen));
                taken_count++;
            end
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (reg_idx_t'(cfg_ch.index))
                    REG_REGION_START: region_lo = cfg_ch.data[PAGE_W-1:0];
                    REG_REGION_END:   region_hi = cfg_ch.data;
                    default:          ;
                endcase
                cfg_beats++;
            end
        end
    end

    // Watchdog: drop the run if it overstays the limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Queue one request; keep at most two ahead of the block so frees see recent allocations.
    task automatic post_request(kind_t k, int pg, int n);
        item_t rq;
        while (items_issued - taken_count >= 2)
            @(negedge clk);
        rq.kind       = k;
        rq.page_index = pg[PAGE_W-1:0];
        rq.count      = n[COUNT_W-1:0];
        requests_pending.push_back(rq);
        items_issued++;
    endtask

    // Hold until every response is back; the block is then idle, as each request answers once.
    task automatic wait_settled();
        while (results_seen != items_issued)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // Write both region registers back to back while the block is idle.
    task automatic set_region(int lo, int hi);
        int target;
        wait_settled();
        target = cfg_beats + 1;
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= REG_REGION_START;
        cfg_ch.data  <= {1'b0, lo[PAGE_W-1:0]};
        do @(negedge clk); while (cfg_beats < target);
        target = cfg_beats + 1;
        cfg_ch.index <= REG_REGION_END;
        cfg_ch.data  <= hi[END_W-1:0];
        do @(negedge clk); while (cfg_beats < target);
        cfg_ch.valid <= 1'b0;
    endtask

    // Run lengths: mostly short, some medium, a few near the maximum.
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 8);
        if (r < 90)
            return $urandom_range(9, 64);
        return $urandom_range(65, MAX_RUN);
    endfunction

    // One random request: allocate, free a held run (sometimes only part of it), or noise.
    task automatic post_random_request();
        int   r;
        int   pick;
        int   off;
        int   n;
        run_t run;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            // noise: any kind, any page, often an illegal count
            n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 511);
            post_request(kind_t'($urandom_range(0, 1)), $urandom_range(0, NUM_PAGES - 1), n);
        end
        else if (r < 48 && held_runs.size() != 0)
        begin
            pick = $urandom_range(0, held_runs.size() - 1);
            run  = held_runs[pick];
            held_runs.delete(pick);
            if ($urandom_range(0, 9) == 0)
            begin
                off = $urandom_range(0, run.len - 1);
                post_request(KIND_FREE, run.first + off, $urandom_range(1, run.len - off));
            end
            else
            begin
                post_request(KIND_FREE, run.first, run.len);
            end
        end
        else
        begin
            post_request(KIND_ALLOC, $urandom_range(0, NUM_PAGES - 1), pick_len());
        end
    endtask

    initial
    begin
        int ph;
        int j;
        int lo;
        int hi;

        // every input known from time zero
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.kind       = KIND_ALLOC;
        req_ch.page_index = '0;
        req_ch.count      = '0;
        rsp_ch.ready      = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = REG_REGION_START;
        cfg_ch.data       = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, reset region first: requests wait out the clearing pass.
        post_request(KIND_ALLOC, NUM_PAGES - 1, MAX_RUN);
        post_request(KIND_ALLOC, 0, 1);
        post_request(KIND_ALLOC, 0, 0);                      // zero count
        post_request(KIND_ALLOC, 0, 511);                    // count above the maximum
        post_request(KIND_FREE, 1024, MAX_RUN);
        post_request(KIND_FREE, 1024, 1);                    // page already free
        post_request(KIND_FREE, 1280, 257);                  // count above the maximum
        post_request(KIND_FREE, NUM_PAGES - 1, MAX_RUN);     // run past the end

        // Ten-page region; the pointer is left outside it, and the third allocate wraps and fails.
        set_region(0, 10);
        post_request(KIND_ALLOC, 0, 4);
        post_request(KIND_ALLOC, 0, 4);
        post_request(KIND_ALLOC, 0, 4);
        post_request(KIND_FREE, 0, 4);
        post_request(KIND_ALLOC, 0, 4);                      // wrap then succeed at the start
        post_request(KIND_FREE, 0, 0);

        // End beyond the store; the pointer wraps to the start after the top window.
        set_region(NUM_PAGES - 4, 32767);
        post_request(KIND_ALLOC, 0, 2);
        post_request(KIND_ALLOC, 0, 2);
        post_request(KIND_ALLOC, 0, 1);                      // region full
        post_request(KIND_FREE, NUM_PAGES - 1, 1);
        post_request(KIND_FREE, 4, 4);                       // run below the region start

        // Empty region: allocates fail, a free ending exactly at the end is still legal.
        set_region(NUM_PAGES - 1, 1);
        post_request(KIND_ALLOC, 0, 1);
        post_request(KIND_FREE, 0, 1);
        post_request(KIND_FREE, 1, 1);                       // one past the end

        // Random phases, each over a fresh region.
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    lo = START_RESET;
                    hi = END_RESET;
                end
                1:
                begin
                    lo = 100;
                    hi = 356;
                end
                2:
                begin
                    lo = 0;
                    hi = 64;
                end
                3:
                begin
                    lo = NUM_PAGES - 64;
                    hi = 32767;
                end
                4:
                begin
                    lo = $urandom_range(0, 15000);
                    hi = lo + $urandom_range(16, 600);
                end
                5:
                begin
                    lo = 9000;
                    hi = 8000;
                end
                6:
                begin
                    lo = 16000;
                    hi = NUM_PAGES;
                end
                default:
                begin
                    lo = $urandom_range(15800, NUM_PAGES - 1);
                    hi = $urandom_range(NUM_PAGES, 32767);
                end
            endcase
            set_region(lo, hi);
            // slow receiver first, then slow sender, then full rate
            if (ph < 3)
            begin
                send_gap_pct = 11;
                recv_gap_pct = 67;
            end
            else if (ph < 6)
            begin
                send_gap_pct = 67;
                recv_gap_pct = 11;
            end
            else
            begin
                send_gap_pct = 0;
                recv_gap_pct = 0;
            end
            for (j = 0; j < PHASE_ITEMS; j++)
                post_random_request();
        end

        wait_settled();
        repeat (40) @(negedge clk);
        if (outcomes_due.size() != 0)
            note_fault($sformatf("%0d responses never arrived", outcomes_due.size()));
        if (faults == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/cpa_pkg.sv
rtl/core/cpa_if.sv
rtl/core/cpa_page_mem.sv
rtl/core/cpa_seq.sv
rtl/core/contiguous_page_allocator.sv
rtl/core/cpa_checker.sv
dv/tb_contiguous_page_allocator.sv
